>>> rtl/core/rrfp_pkg.sv
// ----------------------------------------------------------------------------
// rrfp_pkg
// shared types, codes and constants of the receive frame parser
// ----------------------------------------------------------------------------
package rrfp_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [6:0] ACK_LEN = 7'd5;
  localparam logic [6:0] HEADER_LEN = 7'd11;
  localparam logic [6:0] SEQ_SKIP_OFS = 7'd3;
  localparam int unsigned CRC_OK_BIT = 7;

  localparam logic [15:0] DATA_FC_RST = 16'h8841;
  localparam logic [15:0] ACK_FC_RST = 16'h0002;
  localparam logic [15:0] TYPE_MASK_RST = 16'hFFDF;
  localparam logic [15:0] ACKREQ_MASK_RST = 16'h0020;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_FC   = 3'd0,
    CFG_ACK_FC    = 3'd1,
    CFG_TYPE_MASK = 3'd2,
    CFG_ACKREQ    = 3'd3,
    CFG_DELIVER   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_DELIVERED = 3'd1,
    KIND_ACK       = 3'd2,
    KIND_DISCARDED = 3'd3,
    KIND_FLUSHED   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_SKIP    = 4'd1,
    PH_FC0     = 4'd2,
    PH_FC1     = 4'd3,
    PH_SEQ     = 4'd4,
    PH_ACK0    = 4'd5,
    PH_ACK1    = 4'd6,
    PH_DPAN0   = 4'd7,
    PH_DPAN1   = 4'd8,
    PH_DADR0   = 4'd9,
    PH_DADR1   = 4'd10,
    PH_SRC0    = 4'd11,
    PH_SRC1    = 4'd12,
    PH_PAYLOAD = 4'd13,
    PH_FOOT0   = 4'd14,
    PH_FOOT1   = 4'd15
  } phase_e;

  typedef struct packed {
    logic [15:0] data_fc;
    logic [15:0] ack_fc;
    logic [15:0] type_mask;
    logic [15:0] ackreq_mask;
    logic        deliver_en;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        last_payload;
    logic [6:0]  payload_length;
    logic        ack_requested;
    logic [7:0]  sequence_number;
    logic [15:0] destination_pan;
    logic [15:0] destination_address;
    logic [15:0] source_address;
    logic [7:0]  signal_strength;
    logic        checksum_good;
  } res_t;

endpackage

>>> rtl/core/rrfp_if.sv
// ----------------------------------------------------------------------------
// rrfp channel interfaces
// valid/ready channels for received bytes and for parser results
// ----------------------------------------------------------------------------
interface rrfp_rx_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  logic [7:0] current_tx_seq;

  modport source (output valid, action, rx_byte, current_tx_seq, input ready);
  modport sink (input valid, action, rx_byte, current_tx_seq, output ready);
endinterface

interface rrfp_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic        last_payload;
  logic [6:0]  payload_length;
  logic        ack_requested;
  logic [7:0]  sequence_number;
  logic [15:0] destination_pan;
  logic [15:0] destination_address;
  logic [15:0] source_address;
  logic [7:0]  signal_strength;
  logic        checksum_good;

  modport source (
    output valid, kind, payload_byte, last_payload, payload_length, ack_requested,
           sequence_number, destination_pan, destination_address, source_address,
           signal_strength, checksum_good,
    input  ready
  );
  modport sink (
    input  valid, kind, payload_byte, last_payload, payload_length, ack_requested,
           sequence_number, destination_pan, destination_address, source_address,
           signal_strength, checksum_good,
    output ready
  );
endinterface

>>> rtl/core/rrfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// rrfp_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module rrfp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [rrfp_pkg::CFG_IDX_W-1:0] idx_i,
  input  logic [rrfp_pkg::CFG_DATA_W-1:0] wdata_i,
  output rrfp_pkg::cfg_t                 cfg_o
);

  rrfp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (rrfp_pkg::cfg_idx_e'(idx_i))
        rrfp_pkg::CFG_DATA_FC:   cfg_d.data_fc = wdata_i;
        rrfp_pkg::CFG_ACK_FC:    cfg_d.ack_fc = wdata_i;
        rrfp_pkg::CFG_TYPE_MASK: cfg_d.type_mask = wdata_i;
        rrfp_pkg::CFG_ACKREQ:    cfg_d.ackreq_mask = wdata_i;
        rrfp_pkg::CFG_DELIVER:   cfg_d.deliver_en = wdata_i[0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_fc <= rrfp_pkg::DATA_FC_RST;
      cfg_q.ack_fc <= rrfp_pkg::ACK_FC_RST;
      cfg_q.type_mask <= rrfp_pkg::TYPE_MASK_RST;
      cfg_q.ackreq_mask <= rrfp_pkg::ACKREQ_MASK_RST;
      cfg_q.deliver_en <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/rrfp_parser.sv
// ----------------------------------------------------------------------------
// rrfp_parser
// frame parse state machine, one byte per accepted transaction
// ----------------------------------------------------------------------------
module rrfp_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic           action_i,
  input  logic [7:0]     rx_byte_i,
  input  logic [7:0]     tx_seq_i,
  input  rrfp_pkg::cfg_t cfg_i,
  output logic           res_valid_o,
  output rrfp_pkg::res_t res_o
);

  rrfp_pkg::phase_e phase_q, phase_d;
  logic [6:0]  len_q, len_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [15:0] fc_q, fc_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] dpan_q, dpan_d;
  logic [15:0] dadr_q, dadr_d;
  logic [15:0] src_q, src_d;
  logic [7:0]  rssi_q, rssi_d;

  logic [6:0] cnt_inc;
  logic       last_pl;
  logic       crc_ok;
  logic       is_data;
  logic       ack_req;

  assign cnt_inc = cnt_q + 7'd1;
  assign last_pl = ({1'b0, cnt_inc} + {1'b0, rrfp_pkg::HEADER_LEN}) >= {1'b0, len_q};
  assign crc_ok = rx_byte_i[rrfp_pkg::CRC_OK_BIT];
  assign is_data = (fc_q & cfg_i.type_mask) == cfg_i.data_fc;
  assign ack_req = |(fc_q & cfg_i.ackreq_mask);

  always_comb begin
    phase_d = phase_q;
    len_d = len_q;
    cnt_d = cnt_q;
    fc_d = fc_q;
    seq_d = seq_q;
    dpan_d = dpan_q;
    dadr_d = dadr_q;
    src_d = src_q;
    rssi_d = rssi_q;
    res_valid_o = 1'b0;
    res_o = '0;

    if (fire_i) begin
      if (action_i) begin
        // overflow flush: everything back to reset, config kept
        phase_d = rrfp_pkg::PH_IDLE;
        len_d = '0;
        cnt_d = '0;
        fc_d = '0;
        seq_d = '0;
        dpan_d = '0;
        dadr_d = '0;
        src_d = '0;
        rssi_d = '0;
        res_valid_o = 1'b1;
        res_o.kind = rrfp_pkg::KIND_FLUSHED;
      end else begin
        case (phase_q)
          rrfp_pkg::PH_IDLE: begin
            len_d = rx_byte_i[6:0];
            if (rx_byte_i[6:0] == 7'd0) begin
              phase_d = rrfp_pkg::PH_IDLE;
            end else if (rx_byte_i[6:0] < rrfp_pkg::ACK_LEN) begin
              cnt_d = rx_byte_i[6:0];
              phase_d = rrfp_pkg::PH_SKIP;
            end else begin
              phase_d = rrfp_pkg::PH_FC0;
            end
          end
          rrfp_pkg::PH_SKIP: begin
            cnt_d = cnt_q - 7'd1;
            if (cnt_d == 7'd0) begin
              phase_d = rrfp_pkg::PH_IDLE;
            end
          end
          rrfp_pkg::PH_FC0: begin
            fc_d = {8'h00, rx_byte_i};
            phase_d = rrfp_pkg::PH_FC1;
          end
          rrfp_pkg::PH_FC1: begin
            fc_d = {rx_byte_i, fc_q[7:0]};
            phase_d = rrfp_pkg::PH_SEQ;
          end
          rrfp_pkg::PH_SEQ: begin
            seq_d = rx_byte_i;
            if (len_q == rrfp_pkg::ACK_LEN && fc_q == cfg_i.ack_fc &&
                rx_byte_i == tx_seq_i) begin
              phase_d = rrfp_pkg::PH_ACK0;
            end else if (len_q < rrfp_pkg::HEADER_LEN) begin
              cnt_d = len_q - rrfp_pkg::SEQ_SKIP_OFS;
              phase_d = rrfp_pkg::PH_SKIP;
            end else begin
              phase_d = rrfp_pkg::PH_DPAN0;
            end
          end
          rrfp_pkg::PH_ACK0: begin
            rssi_d = rx_byte_i;
            phase_d = rrfp_pkg::PH_ACK1;
          end
          rrfp_pkg::PH_ACK1: begin
            phase_d = rrfp_pkg::PH_IDLE;
            if (crc_ok) begin
              res_valid_o = 1'b1;
              res_o.kind = rrfp_pkg::KIND_ACK;
              res_o.ack_requested = ack_req;
              res_o.sequence_number = seq_q;
              res_o.signal_strength = rssi_q;
              res_o.checksum_good = 1'b1;
            end
          end
          rrfp_pkg::PH_DPAN0: begin
            dpan_d = {8'h00, rx_byte_i};
            phase_d = rrfp_pkg::PH_DPAN1;
          end
          rrfp_pkg::PH_DPAN1: begin
            dpan_d = {rx_byte_i, dpan_q[7:0]};
            phase_d = rrfp_pkg::PH_DADR0;
          end
          rrfp_pkg::PH_DADR0: begin
            dadr_d = {8'h00, rx_byte_i};
            phase_d = rrfp_pkg::PH_DADR1;
          end
          rrfp_pkg::PH_DADR1: begin
            dadr_d = {rx_byte_i, dadr_q[7:0]};
            phase_d = rrfp_pkg::PH_SRC0;
          end
          rrfp_pkg::PH_SRC0: begin
            src_d = {8'h00, rx_byte_i};
            phase_d = rrfp_pkg::PH_SRC1;
          end
          rrfp_pkg::PH_SRC1: begin
            src_d = {rx_byte_i, src_q[7:0]};
            cnt_d = '0;
            phase_d = (len_q == rrfp_pkg::HEADER_LEN) ? rrfp_pkg::PH_FOOT0
                                                      : rrfp_pkg::PH_PAYLOAD;
          end
          rrfp_pkg::PH_PAYLOAD: begin
            cnt_d = cnt_inc;
            res_valid_o = 1'b1;
            res_o.kind = rrfp_pkg::KIND_PAYLOAD;
            res_o.payload_byte = rx_byte_i;
            res_o.last_payload = last_pl;
            res_o.payload_length = len_q - rrfp_pkg::HEADER_LEN;
            res_o.ack_requested = ack_req;
            res_o.sequence_number = seq_q;
            res_o.destination_pan = dpan_q;
            res_o.destination_address = dadr_q;
            res_o.source_address = src_q;
            if (last_pl) begin
              phase_d = rrfp_pkg::PH_FOOT0;
            end
          end
          rrfp_pkg::PH_FOOT0: begin
            rssi_d = rx_byte_i;
            phase_d = rrfp_pkg::PH_FOOT1;
          end
          rrfp_pkg::PH_FOOT1: begin
            phase_d = rrfp_pkg::PH_IDLE;
            res_valid_o = 1'b1;
            res_o.kind = (cfg_i.deliver_en && is_data && crc_ok) ? rrfp_pkg::KIND_DELIVERED
                                                                : rrfp_pkg::KIND_DISCARDED;
            res_o.payload_length = len_q - rrfp_pkg::HEADER_LEN;
            res_o.ack_requested = ack_req;
            res_o.sequence_number = seq_q;
            res_o.destination_pan = dpan_q;
            res_o.destination_address = dadr_q;
            res_o.source_address = src_q;
            res_o.signal_strength = rssi_q;
            res_o.checksum_good = crc_ok;
          end
          default: phase_d = rrfp_pkg::PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rrfp_pkg::PH_IDLE;
      len_q <= '0;
      cnt_q <= '0;
      fc_q <= '0;
      seq_q <= '0;
      dpan_q <= '0;
      dadr_q <= '0;
      src_q <= '0;
      rssi_q <= '0;
    end else begin
      phase_q <= phase_d;
      len_q <= len_d;
      cnt_q <= cnt_d;
      fc_q <= fc_d;
      seq_q <= seq_d;
      dpan_q <= dpan_d;
      dadr_q <= dadr_d;
      src_q <= src_d;
      rssi_q <= rssi_d;
    end
  end

  // a flush always lands in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && action_i |=> phase_q == rrfp_pkg::PH_IDLE)
    else $error("parser not idle after flush");

  // payload bytes only come out of the payload phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == rrfp_pkg::KIND_PAYLOAD |->
      phase_q == rrfp_pkg::PH_PAYLOAD && !action_i)
    else $error("payload result outside payload phase");

  // last payload byte hands over to the footer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == rrfp_pkg::KIND_PAYLOAD && res_o.last_payload |=>
      phase_q == rrfp_pkg::PH_FOOT0)
    else $error("footer not entered after last payload byte");

  // a skip count never reaches zero while still skipping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rrfp_pkg::PH_SKIP |-> cnt_q != 7'd0)
    else $error("skip phase with empty count");

endmodule

>>> rtl/core/rrfp_out_reg.sv
// ----------------------------------------------------------------------------
// rrfp_out_reg
// result register between parser and downstream sink
// ----------------------------------------------------------------------------
module rrfp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  rrfp_pkg::res_t res_i,
  input  logic           ready_i,
  output logic           valid_o,
  output rrfp_pkg::res_t res_o,
  output logic           free_o
);

  logic           valid_q, valid_d;
  rrfp_pkg::res_t res_q;

  // room for a new result when empty or when the held one leaves this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o = res_q;

  // never overwrite a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result register overwritten");

  // a load always shows up as a valid result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result lost");

endmodule

>>> rtl/core/radio_rx_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// radio_rx_frame_parser_unit
// receive frame parser: length, header, payload and footer of short-address
// radio frames, with ack detection and overflow flush
// ----------------------------------------------------------------------------
// a result is registered and appears on res_o in the cycle after its byte transaction
// throughput: one byte per cycle, limited only by the single result register
// any byte stalls while an untaken result sits in the result register
// reset: parser returns to idle with all held fields zero, result register
// empties, configuration registers take their default values
module radio_rx_frame_parser_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rrfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rrfp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  rrfp_rx_if.sink                         rx_i,
  rrfp_res_if.source                      res_o
);

  rrfp_pkg::cfg_t cfg;
  rrfp_pkg::res_t parse_res;
  rrfp_pkg::res_t held_res;
  logic           parse_valid;
  logic           out_free;
  logic           rx_fire;

  // configuration registers; the user is to write them only while the parser is quiet, the block does not enforce it
  rrfp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // a byte is taken whenever the result register has room for what it makes
  assign rx_i.ready = out_free;
  assign rx_fire = rx_i.valid && out_free;

  // parse state machine: one step per byte transaction
  rrfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (rx_fire),
    .action_i    (rx_i.action),
    .rx_byte_i   (rx_i.rx_byte),
    .tx_seq_i    (rx_i.current_tx_seq),
    .cfg_i       (cfg),
    .res_valid_o (parse_valid),
    .res_o       (parse_res)
  );

  // result register decouples the parser from downstream backpressure
  rrfp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (parse_valid),
    .res_i   (parse_res),
    .ready_i (res_o.ready),
    .valid_o (res_o.valid),
    .res_o   (held_res),
    .free_o  (out_free)
  );

  // unpack the held result onto the channel
  assign res_o.kind = held_res.kind;
  assign res_o.payload_byte = held_res.payload_byte;
  assign res_o.last_payload = held_res.last_payload;
  assign res_o.payload_length = held_res.payload_length;
  assign res_o.ack_requested = held_res.ack_requested;
  assign res_o.sequence_number = held_res.sequence_number;
  assign res_o.destination_pan = held_res.destination_pan;
  assign res_o.destination_address = held_res.destination_address;
  assign res_o.source_address = held_res.source_address;
  assign res_o.signal_strength = held_res.signal_strength;
  assign res_o.checksum_good = held_res.checksum_good;

endmodule
